// ===== sv/rrpg_pkg.sv =====
`default_nettype none

package rrpg_pkg;

   // Arc factor 0.446 as unsigned Q0.16, and the rounding half for the >> 16.
   localparam logic [14:0] ARC_K = 15'd29229;
   localparam logic [15:0] ARC_ROUND = 16'h8000;

   // Default depth of the job queue between front and back.
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [2:0] {
      KIND_MOVE  = 3'd0,
      KIND_LINE  = 3'd1,
      KIND_CUBIC = 3'd2,
      KIND_CLOSE = 3'd3,
      KIND_EMPTY = 3'd4
   } kind_type;

   // Position of the back end within one outline.
   typedef enum logic [3:0] {
      SLOT_START,
      SLOT_TOP,
      SLOT_C1,
      SLOT_RIGHT,
      SLOT_C2,
      SLOT_BOTTOM,
      SLOT_C3,
      SLOT_LEFT,
      SLOT_C4,
      SLOT_CLOSE
   } slot_type;

   // One classified rectangle. For an empty shape the origin is zero; for a
   // plain rectangle the radii are zero, so that the rounded formulas for
   // the move, edge and close points reduce to the plain corners.
   typedef struct packed {
      logic signed [31:0] x_pos;
      logic signed [31:0] y_pos;
      logic [30:0]        rect_width;
      logic [30:0]        rect_height;
      logic [30:0]        rad_x;
      logic [30:0]        rad_y;
      logic [30:0]        off_x;
      logic [30:0]        off_y;
      logic               empty;
      logic               rounded;
      logic               hline;
      logic               vline;
   } job_type;

   // A coordinate written as base + plus - minus.
   typedef struct packed {
      logic signed [31:0] base;
      logic [30:0]        plus;
      logic [30:0]        minus;
   } term_type;

   // Exact sum in 34 bits, then saturation to the signed 32 bit range.
   function automatic logic signed [31:0] sat_coord(input term_type t);
      logic [33:0] s;
      logic signed [31:0] r;
      s = {{2{t.base[31]}}, t.base} + {3'b000, t.plus} - {3'b000, t.minus};
      if (!s[33] && (s[32] || s[31])) begin
         r = 32'sh7FFF_FFFF;
      end else if (s[33] && !(s[32] && s[31])) begin
         r = 32'sh8000_0000;
      end else begin
         r = s[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/rrpg_front.sv =====
`default_nettype none

module rrpg_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output      logic               in_ready,
   input  wire logic signed [31:0] x_pos,
   input  wire logic signed [31:0] y_pos,
   input  wire logic [30:0]        rect_width,
   input  wire logic [30:0]        rect_height,
   input  wire logic [30:0]        corner_rx,
   input  wire logic               rx_given,
   input  wire logic [30:0]        corner_ry,
   input  wire logic               ry_given,
   output      logic               push_valid,
   input  wire logic               push_ready,
   output      rrpg_pkg::job_type  push_job
);

   logic              a_valid_ff, a_valid_in;
   rrpg_pkg::job_type a_job_ff, a_job_in;
   logic              accept, push;
   logic [30:0]       rx_sel, ry_sel, rx_clamp, ry_clamp;
   logic              rx_big, ry_big, empty, rounded;
   logic [46:0]       prod_x, prod_y;

   assign push     = a_valid_ff && push_ready;
   assign in_ready = !a_valid_ff || push_ready;
   assign accept   = in_valid && in_ready;

   // Classification: resolve missing radii, clamp to the half sides.
   always_comb begin
      rx_sel   = rx_given ? corner_rx : (ry_given ? corner_ry : 31'd0);
      ry_sel   = ry_given ? corner_ry : (rx_given ? corner_rx : 31'd0);
      rx_big   = {rx_sel, 1'b0} >= {1'b0, rect_width};
      ry_big   = {ry_sel, 1'b0} >= {1'b0, rect_height};
      rx_clamp = rx_big ? {1'b0, rect_width[30:1]} : rx_sel;
      ry_clamp = ry_big ? {1'b0, rect_height[30:1]} : ry_sel;
      empty    = (rect_width == 31'd0) || (rect_height == 31'd0);
      rounded  = !empty && (rx_clamp != 31'd0) && (ry_clamp != 31'd0);

      a_job_in             = '0;
      a_job_in.x_pos       = empty ? 32'sd0 : x_pos;
      a_job_in.y_pos       = empty ? 32'sd0 : y_pos;
      a_job_in.rect_width  = rect_width;
      a_job_in.rect_height = rect_height;
      a_job_in.rad_x       = rounded ? rx_clamp : 31'd0;
      a_job_in.rad_y       = rounded ? ry_clamp : 31'd0;
      a_job_in.empty       = empty;
      a_job_in.rounded     = rounded;
      a_job_in.hline       = !rx_big;
      a_job_in.vline       = !ry_big;
   end

   always_comb begin
      priority if (accept) begin
         a_valid_in = 1'b1;
      end else if (push) begin
         a_valid_in = 1'b0;
      end else begin
         a_valid_in = a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_job_ff <= a_job_in;
      end
   end

   // Control offsets, rounded to nearest; the queue entry registers them.
   assign prod_x = 47'(a_job_ff.rad_x) * 47'(rrpg_pkg::ARC_K) + 47'(rrpg_pkg::ARC_ROUND);
   assign prod_y = 47'(a_job_ff.rad_y) * 47'(rrpg_pkg::ARC_K) + 47'(rrpg_pkg::ARC_ROUND);

   always_comb begin
      push_job       = a_job_ff;
      push_job.off_x = prod_x[46:16];
      push_job.off_y = prod_y[46:16];
   end

   assign push_valid = a_valid_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !push_ready |=> a_valid_ff)
      else $error("front stage dropped a rectangle while the queue was full");

endmodule

`default_nettype wire

// ===== sv/rrpg_queue.sv =====
`default_nettype none

module rrpg_queue #(
   parameter int DEPTH = rrpg_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output      logic              push_ready,
   input  wire rrpg_pkg::job_type push_job,
   output      logic              head_valid,
   input  wire logic              pop,
   output      rrpg_pkg::job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rrpg_pkg::job_type  mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign head_valid = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;
   assign head_job   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("job queue count exceeds its depth");

endmodule

`default_nettype wire

// ===== sv/rrpg_back.sv =====
`default_nettype none

module rrpg_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              job_valid,
   input  wire rrpg_pkg::job_type job,
   output      logic              job_pop,
   output      logic              out_valid,
   input  wire logic              out_ready,
   output      logic [2:0]        out_kind,
   output      logic [191:0]      out_data,
   output      logic              out_last
);

   rrpg_pkg::slot_type slot_ff, slot_in, slot_nxt;
   rrpg_pkg::kind_type kind;
   rrpg_pkg::term_type t_c1x, t_c1y, t_c2x, t_c2y, t_ex, t_ey;
   logic               last, advance;
   logic               valid_ff, valid_in;
   logic [2:0]         kind_ff;
   logic [191:0]       data_ff;
   logic               last_ff;

   assign advance = job_valid && (!valid_ff || out_ready);
   assign job_pop = advance && last;

   // Next outline position, skipping collapsed edges and square corners.
   always_comb begin
      unique case (slot_ff)
         rrpg_pkg::SLOT_START: begin
            if (job.empty) begin
               slot_nxt = rrpg_pkg::SLOT_START;
            end else if (job.rounded && !job.hline) begin
               slot_nxt = rrpg_pkg::SLOT_C1;
            end else begin
               slot_nxt = rrpg_pkg::SLOT_TOP;
            end
         end
         rrpg_pkg::SLOT_TOP:
            slot_nxt = job.rounded ? rrpg_pkg::SLOT_C1 : rrpg_pkg::SLOT_RIGHT;
         rrpg_pkg::SLOT_C1:
            slot_nxt = job.vline ? rrpg_pkg::SLOT_RIGHT : rrpg_pkg::SLOT_C2;
         rrpg_pkg::SLOT_RIGHT:
            slot_nxt = job.rounded ? rrpg_pkg::SLOT_C2 : rrpg_pkg::SLOT_BOTTOM;
         rrpg_pkg::SLOT_C2:
            slot_nxt = job.hline ? rrpg_pkg::SLOT_BOTTOM : rrpg_pkg::SLOT_C3;
         rrpg_pkg::SLOT_BOTTOM:
            slot_nxt = job.rounded ? rrpg_pkg::SLOT_C3 : rrpg_pkg::SLOT_CLOSE;
         rrpg_pkg::SLOT_C3:
            slot_nxt = job.vline ? rrpg_pkg::SLOT_LEFT : rrpg_pkg::SLOT_C4;
         rrpg_pkg::SLOT_LEFT:  slot_nxt = rrpg_pkg::SLOT_C4;
         rrpg_pkg::SLOT_C4:    slot_nxt = rrpg_pkg::SLOT_CLOSE;
         rrpg_pkg::SLOT_CLOSE: slot_nxt = rrpg_pkg::SLOT_START;
         default:              slot_nxt = rrpg_pkg::SLOT_START;
      endcase
      slot_in = advance ? slot_nxt : slot_ff;
   end

   // Segment contents for the current position.
   always_comb begin
      t_c1x = '0;
      t_c1y = '0;
      t_c2x = '0;
      t_c2y = '0;
      t_ex  = '{job.x_pos, job.rad_x, 31'd0};
      t_ey  = '{job.y_pos, 31'd0, 31'd0};
      kind  = rrpg_pkg::KIND_LINE;
      last  = 1'b0;
      unique case (slot_ff)
         rrpg_pkg::SLOT_START: begin
            kind = job.empty ? rrpg_pkg::KIND_EMPTY : rrpg_pkg::KIND_MOVE;
            last = job.empty;
         end
         rrpg_pkg::SLOT_TOP: begin
            t_ex = '{job.x_pos, job.rect_width, job.rad_x};
         end
         rrpg_pkg::SLOT_C1: begin
            kind  = rrpg_pkg::KIND_CUBIC;
            t_c1x = '{job.x_pos, job.rect_width, job.off_x};
            t_c1y = '{job.y_pos, 31'd0, 31'd0};
            t_c2x = '{job.x_pos, job.rect_width, 31'd0};
            t_c2y = '{job.y_pos, job.off_y, 31'd0};
            t_ex  = '{job.x_pos, job.rect_width, 31'd0};
            t_ey  = '{job.y_pos, job.rad_y, 31'd0};
         end
         rrpg_pkg::SLOT_RIGHT: begin
            t_ex = '{job.x_pos, job.rect_width, 31'd0};
            t_ey = '{job.y_pos, job.rect_height, job.rad_y};
         end
         rrpg_pkg::SLOT_C2: begin
            kind  = rrpg_pkg::KIND_CUBIC;
            t_c1x = '{job.x_pos, job.rect_width, 31'd0};
            t_c1y = '{job.y_pos, job.rect_height, job.off_y};
            t_c2x = '{job.x_pos, job.rect_width, job.off_x};
            t_c2y = '{job.y_pos, job.rect_height, 31'd0};
            t_ex  = '{job.x_pos, job.rect_width, job.rad_x};
            t_ey  = '{job.y_pos, job.rect_height, 31'd0};
         end
         rrpg_pkg::SLOT_BOTTOM: begin
            t_ey = '{job.y_pos, job.rect_height, 31'd0};
         end
         rrpg_pkg::SLOT_C3: begin
            kind  = rrpg_pkg::KIND_CUBIC;
            t_c1x = '{job.x_pos, job.off_x, 31'd0};
            t_c1y = '{job.y_pos, job.rect_height, 31'd0};
            t_c2x = '{job.x_pos, 31'd0, 31'd0};
            t_c2y = '{job.y_pos, job.rect_height, job.off_y};
            t_ex  = '{job.x_pos, 31'd0, 31'd0};
            t_ey  = '{job.y_pos, job.rect_height, job.rad_y};
         end
         rrpg_pkg::SLOT_LEFT: begin
            t_ex = '{job.x_pos, 31'd0, 31'd0};
            t_ey = '{job.y_pos, job.rad_y, 31'd0};
         end
         rrpg_pkg::SLOT_C4: begin
            kind  = rrpg_pkg::KIND_CUBIC;
            t_c1x = '{job.x_pos, 31'd0, 31'd0};
            t_c1y = '{job.y_pos, job.off_y, 31'd0};
            t_c2x = '{job.x_pos, job.off_x, 31'd0};
            t_c2y = '{job.y_pos, 31'd0, 31'd0};
         end
         rrpg_pkg::SLOT_CLOSE: begin
            kind = rrpg_pkg::KIND_CLOSE;
            last = 1'b1;
         end
         default: begin
            kind = rrpg_pkg::KIND_EMPTY;
            last = 1'b1;
         end
      endcase
   end

   always_comb begin
      priority if (advance) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= rrpg_pkg::SLOT_START;
         valid_ff <= 1'b0;
      end else begin
         slot_ff  <= slot_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kind_ff <= kind;
         last_ff <= last;
         data_ff <= {rrpg_pkg::sat_coord(t_ey), rrpg_pkg::sat_coord(t_ex),
                     rrpg_pkg::sat_coord(t_c2y), rrpg_pkg::sat_coord(t_c2x),
                     rrpg_pkg::sat_coord(t_c1y), rrpg_pkg::sat_coord(t_c1x)};
      end
   end

   assign out_valid = valid_ff;
   assign out_kind  = kind_ff;
   assign out_data  = data_ff;
   assign out_last  = last_ff;

   last_kind: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (last_ff == ((kind_ff == rrpg_pkg::KIND_CLOSE) ||
                                (kind_ff == rrpg_pkg::KIND_EMPTY))))
      else $error("last flag does not match the segment kind");

   empty_zero: assert property (@(posedge clock) disable iff (reset)
      valid_ff && (kind_ff == rrpg_pkg::KIND_EMPTY) |-> (data_ff == '0))
      else $error("empty shape carries nonzero coordinates");

endmodule

`default_nettype wire

// ===== sv/rounded_rect_path_generator_core.sv =====
`default_nettype none

// A rectangle accepted by the front stage passes through the job queue and the back end's
// output register before rsp_tvalid rises with its first segment. Throughput: one segment
// per cycle while rsp_tready is high and a job waits, set by the back end's single output
// register; a rectangle yields 1 segment (empty), 5 (plain) or 6 to 10 (rounded), then the
// next follows. Reset (synchronous, active high) empties the front stage, queue and output.
module rounded_rect_path_generator_core #(
   parameter int QUEUE_DEPTH = rrpg_pkg::QUEUE_DEPTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   // x_pos[31:0], y_pos[63:32], rect_width[94:64], rect_height[125:95],
   // corner_rx[156:126], corner_ry[187:157], zero fill[191:188]
   input  wire logic [191:0] req_tdata,
   // rx_given[0], ry_given[1]
   input  wire logic [1:0]   req_tuser,
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   // ctrl1_x[31:0], ctrl1_y[63:32], ctrl2_x[95:64], ctrl2_y[127:96],
   // end_x[159:128], end_y[191:160]
   output      logic [191:0] rsp_tdata,
   // segment_kind[2:0]
   output      logic [2:0]   rsp_tuser,
   // last_segment
   output      logic         rsp_tlast
);

   // The front stage resolves and clamps the radii and works out the
   // control offsets; each classified rectangle becomes one queue entry.
   // The back end walks the outline one segment per word, so a long
   // rounded outline does not hold up acceptance of further rectangles
   // until the queue fills.

   logic              push_valid, push_ready;
   rrpg_pkg::job_type push_job;
   logic              head_valid, head_pop;
   rrpg_pkg::job_type head_job;

   rrpg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .x_pos       (req_tdata[31:0]),
      .y_pos       (req_tdata[63:32]),
      .rect_width  (req_tdata[94:64]),
      .rect_height (req_tdata[125:95]),
      .corner_rx   (req_tdata[156:126]),
      .rx_given    (req_tuser[0]),
      .corner_ry   (req_tdata[187:157]),
      .ry_given    (req_tuser[1]),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_job    (push_job)
   );

   rrpg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .head_valid (head_valid),
      .pop        (head_pop),
      .head_job   (head_job)
   );

   // The back end pops an entry only with the word that ends its outline.
   rrpg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (head_valid),
      .job       (head_job),
      .job_pop   (head_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_kind  (rsp_tuser),
      .out_data  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

   // A move word opens every non-empty outline, so it can never close one.
   move_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == rrpg_pkg::KIND_MOVE) |-> !rsp_tlast)
      else $error("move segment flagged as the last of its outline");

endmodule

`default_nettype wire
